// ----- hw/rtl/shs_pkg.sv -----
package shs_pkg;

  localparam int unsigned OpW   = 8;
  localparam int unsigned StepW = 4;
  localparam int unsigned ByteW = 8;

  localparam logic [StepW-1:0] IDLE_STEP   = 4'd8;
  localparam logic [ByteW-1:0] ROTOR_LIMIT = 8'd60;

  // Command codes
  localparam logic [OpW-1:0] OP_FWD1 = 8'd0;
  localparam logic [OpW-1:0] OP_BACK1 = 8'd1;
  localparam logic [OpW-1:0] OP_FWD2 = 8'd2;
  localparam logic [OpW-1:0] OP_BACK2 = 8'd3;
  localparam logic [OpW-1:0] OP_HOLD = 8'd4;
  localparam logic [OpW-1:0] OP_STOP = 8'd6;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [ByteW-1:0] rotor_cnt;
    logic [ByteW-1:0] gate_a;
    logic [ByteW-1:0] gate_b;
  } cmd_t;

  typedef struct packed {
    logic [StepW-1:0] step_out;
    logic [3:0]       phase_drive;
    logic             wave_valid;
    logic [ByteW-1:0] wave_value;
  } res_t;

  // Half-step drive pattern; idle and anything beyond it drive no phase.
  function automatic logic [3:0] phase_of(input logic [StepW-1:0] step);
    logic [3:0] pat;
    case (step)
      4'd0:    pat = 4'h9;
      4'd1:    pat = 4'h1;
      4'd2:    pat = 4'h3;
      4'd3:    pat = 4'h2;
      4'd4:    pat = 4'h6;
      4'd5:    pat = 4'h4;
      4'd6:    pat = 4'hC;
      4'd7:    pat = 4'h8;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

// ----- hw/rtl/shs_stream_if.sv -----
interface shs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/stepper_half_step_sequencer.sv -----
// Channel  | Dir | Word                                         | Handshake
// cmd_i    | in  | op, rotor_cnt, gate_a, gate_b                | valid/ready
// res_o    | out | step_out, phase_drive, wave_valid, wave_value | valid/ready
//
// A command is first held in the input register, then its result is loaded
// into the output register, which drives res_o. One command per cycle
// sustained while res_o is taken; the step/sync/mode state updates as the
// command moves into the output register, so the next one sees it directly.
// rst_ni clears both stages and returns the index to idle (8).
// A stalled output backs up into the input register; ready drops only when
// both stages are full and res_o is not taken.
module stepper_half_step_sequencer (
  input  logic         clk_i,
  input  logic         rst_ni,
  shs_stream_if.sink   cmd_i,
  shs_stream_if.source res_o
);
  import shs_pkg::*;

  logic in_vld_q;
  cmd_t in_q;
  logic out_vld_q;
  res_t out_q;

  logic [StepW-1:0] step_q, step_d;
  logic [StepW-1:0] sync_q, sync_d;
  logic [OpW-1:0]   mode_q;

  logic out_adv, in_adv, in_take;
  res_t res_d;

  assign out_adv     = !out_vld_q || res_o.ready;
  assign in_adv      = in_vld_q && out_adv;
  assign cmd_i.ready = !in_vld_q || out_adv;
  assign in_take     = cmd_i.valid && cmd_i.ready;

  assign res_o.valid = out_vld_q;
  assign res_o.data  = out_q;

  always_comb begin
    logic [StepW-1:0] s;
    logic [2:0]       s3, sy3;
    logic             held, odd, wv;
    logic [ByteW-1:0] rp, wval;
    s      = step_q;
    s3     = step_q[2:0];
    sy3    = sync_q[2:0];
    held   = (mode_q == OP_HOLD);
    odd    = step_q[0];
    rp     = in_q.rotor_cnt;
    wv     = 1'b0;
    wval   = '0;
    sync_d = sync_q;
    case (in_q.op)
      OP_FWD1: begin
        s = {1'b0, s3 + 3'd1};
        if (!s[0] && rp < ROTOR_LIMIT) begin
          wv   = 1'b1;
          wval = rp + 8'd1;
        end
      end
      OP_BACK1: begin
        if (step_q == IDLE_STEP) begin
          s = {1'b0, sy3 - 3'd1};
        end else begin
          s = {1'b0, s3 - 3'd1};
          if (rp == 8'd1 && !held && (in_q.gate_a == 8'd1 || in_q.gate_b == 8'd1)) begin
            wv   = 1'b1;
            wval = '0;
          end
        end
        // even landing overrides the zero word
        if (!s[0] && !held && rp != '0) begin
          wv   = 1'b1;
          wval = rp - 8'd1;
        end
      end
      OP_FWD2: begin
        if (held || odd) begin
          s = (step_q == IDLE_STEP) ? {1'b0, sy3 + 3'd1} : {1'b0, s3 + 3'd1};
        end else begin
          s = {1'b0, s3 + 3'd2};
        end
        if (rp < ROTOR_LIMIT) begin
          wv   = 1'b1;
          wval = rp + 8'd1;
        end
      end
      OP_BACK2: begin
        if (held || odd) begin
          if (step_q == IDLE_STEP) begin
            s = {1'b0, sy3 - 3'd1};
          end else begin
            s = {1'b0, s3 - 3'd1};
            if (rp == 8'd1 && !held) begin
              wv   = 1'b1;
              wval = '0;
            end
          end
        end else begin
          s = {1'b0, s3 - 3'd2};
          if (rp != '0) begin
            wv   = 1'b1;
            wval = rp - 8'd1;
          end
        end
      end
      OP_HOLD: begin
        if (step_q == IDLE_STEP) begin
          s = sync_q;
        end else if (!odd) begin
          s      = {1'b0, s3 + 3'd1};
          sync_d = s;
        end else begin
          s = IDLE_STEP;
        end
      end
      OP_STOP: s = IDLE_STEP;
      default: s = step_q;
    endcase
    step_d            = s;
    res_d.step_out    = s;
    res_d.phase_drive = phase_of(s);
    res_d.wave_valid  = wv;
    res_d.wave_value  = wval;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      step_q    <= IDLE_STEP;
      sync_q    <= '0;
      mode_q    <= '0;
    end else begin
      if (cmd_i.ready) begin
        in_vld_q <= cmd_i.valid;
      end
      if (out_adv) begin
        out_vld_q <= in_vld_q;
      end
      // advance state as the word moves to the output register
      if (in_adv) begin
        step_q <= step_d;
        sync_q <= sync_d;
        mode_q <= in_q.op;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= cmd_i.data;
    end
    if (in_adv) begin
      out_q <= res_d;
    end
  end

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_q.step_out <= IDLE_STEP)
    else $error("step index out of range");

  a_wave_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.wave_valid) |-> out_q.wave_value == '0)
    else $error("wave byte set without wave_valid");

  a_phase_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_q.phase_drive == phase_of(out_q.step_out))
    else $error("phase nibble does not match index");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.ready |-> (in_vld_q && out_vld_q))
    else $error("input stalled with a free stage");

  a_stop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_adv && in_q.op == OP_STOP) |=> (step_q == IDLE_STEP && out_q.step_out == IDLE_STEP))
    else $error("stop did not park the index");

endmodule
